[hw/rtl/hhvb_pkg.sv]
`timescale 1ns / 1ps

package hhvb_pkg;

    // Field widths fixed by the item format
    localparam int DIST_W      = 32;
    localparam int SAMPLE_W    = 10;
    localparam int DEPTH_W     = 3;
    localparam int HIST_FIELDS = 7;

    // Defaults for the top-level parameters
    localparam int HISTORY_SIZE_DEF = 8;
    localparam int NUM_SAMPLES_DEF  = 1024;

    // Positive infinity as a single-precision bit pattern
    localparam logic [DIST_W-1:0] DIST_INF = 32'h7F80_0000;

    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_CHECK  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture the incoming item
        logic clr_step;  // write one infinity row during the clear pass
        logic rd_en;     // read the addressed row
        logic eval;      // compare, write back, strobe the result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;  // clear pass is on its last row
    } t_sts;

endpackage

[hw/rtl/hhvb_ram.sv]
`timescale 1ns / 1ps

module hhvb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/hhvb_ctrl.sv]
`timescale 1ns / 1ps

module hhvb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  hhvb_pkg::t_sts i_sts,
    output hhvb_pkg::t_cmd o_cmd,
    output logic          o_busy
);

    import hhvb_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = ST_EVAL;
            end
            ST_EVAL: begin
                // write back now; the next item's read follows the write
                o_cmd.eval = 1'b1;
                o_busy     = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_READ;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

[hw/rtl/hhvb_dpath.sv]
`timescale 1ns / 1ps

module hhvb_dpath #(
    parameter int HISTORY_SIZE = hhvb_pkg::HISTORY_SIZE_DEF,
    parameter int NUM_SAMPLES  = hhvb_pkg::NUM_SAMPLES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hhvb_pkg::t_cmd                i_cmd,
    output hhvb_pkg::t_sts                o_sts,
    input  logic                          i_operation,
    input  logic [hhvb_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [hhvb_pkg::DEPTH_W-1:0]  i_depth,
    input  logic [hhvb_pkg::DIST_W-1:0]   i_new_distance,
    input  logic [hhvb_pkg::DIST_W-1:0]   i_history_0,
    input  logic [hhvb_pkg::DIST_W-1:0]   i_history_1,
    input  logic [hhvb_pkg::DIST_W-1:0]   i_history_2,
    input  logic [hhvb_pkg::DIST_W-1:0]   i_history_3,
    input  logic [hhvb_pkg::DIST_W-1:0]   i_history_4,
    input  logic [hhvb_pkg::DIST_W-1:0]   i_history_5,
    input  logic [hhvb_pkg::DIST_W-1:0]   i_history_6,
    output logic                          o_valid,
    output logic                          o_accepted
);

    import hhvb_pkg::*;

    localparam int AW    = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
    localparam int ROW_W = HISTORY_SIZE * DIST_W;

    t_op                r_op;
    logic [AW-1:0]      r_addr;
    logic               r_ok;
    logic [DEPTH_W-1:0] r_depth;
    logic [DIST_W-1:0]  r_dist;
    logic [DIST_W-1:0]  r_hist [HIST_FIELDS];
    logic [AW-1:0]      r_clr_cnt;
    logic               r_valid;
    logic               r_accepted;

    logic               sample_ok;
    logic               depth_ok;
    logic [ROW_W-1:0]   rd_row;
    logic [ROW_W-1:0]   new_row;
    logic [ROW_W-1:0]   wr_row;
    logic [AW-1:0]      wr_addr;
    logic               wr_en;
    logic [DIST_W-1:0]  stored   [HISTORY_SIZE];
    logic [DIST_W-1:0]  hist_ext [HISTORY_SIZE];
    logic               diff_found;
    logic               diff_lt;
    logic [DIST_W-1:0]  at_depth;
    logic               upd_wr;
    logic               chk_ok;
    logic               n_accepted;

    // Range checks on the incoming item
    assign sample_ok = 32'(i_sample) < 32'(NUM_SAMPLES);
    assign depth_ok  = 32'(i_depth) < 32'(HISTORY_SIZE);

    // Capture the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= t_op'(i_operation);
            r_addr   <= AW'(i_sample);
            r_ok     <= sample_ok && depth_ok;
            r_depth  <= i_depth;
            r_dist   <= i_new_distance;
            r_hist[0] <= i_history_0;
            r_hist[1] <= i_history_1;
            r_hist[2] <= i_history_2;
            r_hist[3] <= i_history_3;
            r_hist[4] <= i_history_4;
            r_hist[5] <= i_history_5;
            r_hist[6] <= i_history_6;
        end
    end

    // Advance the clear pass row counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_cnt <= r_clr_cnt + AW'(1);
        end
    end

    assign o_sts.clr_last = (r_clr_cnt == AW'(NUM_SAMPLES - 1));

    // Split the row into slots; past the history ports use the stored slot
    for (genvar k = 0; k < HISTORY_SIZE; k++) begin : g_slot
        assign stored[k] = rd_row[k*DIST_W +: DIST_W];
        if (k < HIST_FIELDS) begin : g_hist
            assign hist_ext[k] = r_hist[k];
        end else begin : g_pad
            assign hist_ext[k] = stored[k];
        end
        // New row: history below depth, t at depth, infinity above
        assign new_row[k*DIST_W +: DIST_W] =
            (DEPTH_W'(k) < r_depth)  ? hist_ext[k] :
            (DEPTH_W'(k) == r_depth) ? r_dist      : DIST_INF;
    end

    // Find the first differing prefix slot and the entry at depth
    always_comb begin
        diff_found = 1'b0;
        diff_lt    = 1'b0;
        at_depth   = DIST_INF;
        for (int k = 0; k < HISTORY_SIZE; k++) begin
            if (!diff_found && (DEPTH_W'(k) < r_depth) && (hist_ext[k] != stored[k])) begin
                diff_found = 1'b1;
                diff_lt    = hist_ext[k] < stored[k];
            end
            if (DEPTH_W'(k) == r_depth) begin
                at_depth = stored[k];
            end
        end
    end

    // Decide the write and the result
    assign upd_wr = r_ok && (r_op == OP_UPDATE) &&
                    (diff_found ? diff_lt : (r_dist < at_depth));
    assign chk_ok = r_ok && !diff_found;
    assign n_accepted = (r_op == OP_UPDATE) ? upd_wr : chk_ok;

    // Write port: infinity rows during the clear pass, else the new row
    assign wr_en   = i_cmd.clr_step || (i_cmd.eval && upd_wr);
    assign wr_addr = i_cmd.clr_step ? r_clr_cnt : r_addr;
    assign wr_row  = i_cmd.clr_step ? {HISTORY_SIZE{DIST_INF}} : new_row;

    hhvb_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SAMPLES),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_row),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_addr),
        .o_rdata (rd_row)
    );

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.eval;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_accepted <= n_accepted;
        end
    end

    assign o_valid    = r_valid;
    assign o_accepted = r_accepted;

endmodule

[hw/rtl/hit_history_visibility_buffer.sv]
`timescale 1ns / 1ps

// Hit history visibility buffer: one row of HISTORY_SIZE hit distances per
// pixel sample, held in a single-port-write, registered-read row memory.
// Input channel: an item is taken at a rising edge with i_start high and
// o_busy low. Operation update compares the ray's prefix with the stored
// row and may rewrite it; operation check reports a prefix match.
// Result channel: o_valid strobes for exactly one cycle with o_accepted;
// the receiver cannot stall, so every result must be taken when shown.
// After the accepting edge the row is read, then compared and written
// back, and the result is registered. A new item is refused while the
// row read is pending and may be taken during the write-back, whose row
// the next read sees; this keeps back-to-back items on one sample correct.
// Reset: after i_rst_n is released the block sweeps all NUM_SAMPLES rows
// to infinity, one row per cycle, with o_busy high until the last row.
// Items with a sample or depth out of range return accepted = 0.
module hit_history_visibility_buffer #(
    parameter int HISTORY_SIZE = hhvb_pkg::HISTORY_SIZE_DEF,
    parameter int NUM_SAMPLES  = hhvb_pkg::NUM_SAMPLES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_operation,
    input  logic [hhvb_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [hhvb_pkg::DEPTH_W-1:0]  i_depth,
    input  logic [hhvb_pkg::DIST_W-1:0]   i_new_distance,
    input  logic [hhvb_pkg::DIST_W-1:0]   i_history_0,
    input  logic [hhvb_pkg::DIST_W-1:0]   i_history_1,
    input  logic [hhvb_pkg::DIST_W-1:0]   i_history_2,
    input  logic [hhvb_pkg::DIST_W-1:0]   i_history_3,
    input  logic [hhvb_pkg::DIST_W-1:0]   i_history_4,
    input  logic [hhvb_pkg::DIST_W-1:0]   i_history_5,
    input  logic [hhvb_pkg::DIST_W-1:0]   i_history_6,
    output logic                          o_valid,
    output logic                          o_accepted
);

    import hhvb_pkg::*;

    t_cmd cmd;
    t_sts sts;

    hhvb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    hhvb_dpath #(
        .HISTORY_SIZE (HISTORY_SIZE),
        .NUM_SAMPLES  (NUM_SAMPLES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_operation    (i_operation),
        .i_sample       (i_sample),
        .i_depth        (i_depth),
        .i_new_distance (i_new_distance),
        .i_history_0    (i_history_0),
        .i_history_1    (i_history_1),
        .i_history_2    (i_history_2),
        .i_history_3    (i_history_3),
        .i_history_4    (i_history_4),
        .i_history_5    (i_history_5),
        .i_history_6    (i_history_6),
        .o_valid        (o_valid),
        .o_accepted     (o_accepted)
    );

endmodule

[hw/rtl/hhvb_checker.sv]
`timescale 1ns / 1ps

module hhvb_props #(
    parameter int HISTORY_SIZE = hhvb_pkg::HISTORY_SIZE_DEF,
    parameter int NUM_SAMPLES  = hhvb_pkg::NUM_SAMPLES_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_start,
    input logic                          o_busy,
    input logic                          i_operation,
    input logic [hhvb_pkg::SAMPLE_W-1:0] i_sample,
    input logic [hhvb_pkg::DEPTH_W-1:0]  i_depth,
    input logic                          o_valid,
    input logic                          o_accepted
);

    import hhvb_pkg::*;

    logic take;
    logic chk_empty;
    logic bad_item;

    assign take      = i_start && !o_busy;
    assign chk_empty = take && (i_operation == OP_CHECK) && (i_depth == '0) &&
                       (32'(i_sample) < 32'(NUM_SAMPLES));
    assign bad_item  = take && ((32'(i_depth) >= 32'(HISTORY_SIZE)) ||
                                (32'(i_sample) >= 32'(NUM_SAMPLES)));

    // Every item yields its result strobe
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> ##3 o_valid)
        else $error("item accepted without a result three edges later");

    // No result strobe without a matching earlier item
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(take, 3))
        else $error("result strobe without a matching item");

    // The block is busy in the cycle after taking an item
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> o_busy)
        else $error("second item taken while the row read is pending");

    // An empty prefix always matches
    a_empty_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chk_empty |-> ##3 o_accepted)
        else $error("check with depth zero did not report a match");

    // A sample or depth out of range is never accepted
    a_out_of_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bad_item |-> ##3 !o_accepted)
        else $error("item out of range reported as accepted");

endmodule

bind hit_history_visibility_buffer hhvb_props #(
    .HISTORY_SIZE (HISTORY_SIZE),
    .NUM_SAMPLES  (NUM_SAMPLES)
) u_hhvb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .i_operation (i_operation),
    .i_sample    (i_sample),
    .i_depth     (i_depth),
    .o_valid     (o_valid),
    .o_accepted  (o_accepted)
);

[verif/hhvb_checker.sv]
`timescale 1ns / 1ps

module hhvb_checker #(
    parameter int HISTORY_SIZE = hhvb_pkg::HISTORY_SIZE_DEF,
    parameter int NUM_SAMPLES  = hhvb_pkg::NUM_SAMPLES_DEF
) (
    input  logic                                                   i_clk,
    input  logic                                                   i_rst_n,
    input  logic                                                   i_start,
    input  logic                                                   i_busy,
    input  logic                                                   i_operation,
    input  logic [hhvb_pkg::SAMPLE_W-1:0]                          i_sample,
    input  logic [hhvb_pkg::DEPTH_W-1:0]                           i_depth,
    input  logic [hhvb_pkg::DIST_W-1:0]                            i_new_distance,
    input  logic [hhvb_pkg::HIST_FIELDS-1:0][hhvb_pkg::DIST_W-1:0] i_history,
    input  logic                                                   i_valid,
    input  logic                                                   i_accepted,
    output int                                                     o_fail_count,
    output int                                                     o_pending
);

    import hhvb_pkg::*;

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        t_op                 op;
        logic                accepted;
    } t_verdict;

    // Shadow copy of the distance rows
    logic [DIST_W-1:0] dist_rows [NUM_SAMPLES][HISTORY_SIZE];
    t_verdict          verdict_q [$];
    int                n_fail;

    // Work out the accepted bit of one item and apply its row write
    function automatic logic predict_accepted(
        t_op                                 op,
        int unsigned                         row,
        int unsigned                         dep,
        logic [HIST_FIELDS-1:0][DIST_W-1:0]  hist,
        logic [DIST_W-1:0]                   t_new
    );
        int unsigned i;
        int unsigned pos;
        logic        diverged;
        if (row >= NUM_SAMPLES || dep >= HISTORY_SIZE)
            return 1'b0;
        if (op == OP_CHECK) begin
            for (i = 0; i < dep; i++)
                if (hist[i] != dist_rows[row][i])
                    return 1'b0;
            return 1'b1;
        end
        // Lexicographic compare of the ray prefix against the stored row
        pos      = dep;
        diverged = 1'b0;
        for (i = 0; i < dep && !diverged; i++) begin
            if (hist[i] < dist_rows[row][i]) begin
                pos      = i;
                diverged = 1'b1;
            end else if (hist[i] > dist_rows[row][i]) begin
                return 1'b0;
            end
        end
        if (diverged) begin
            for (i = pos; i < dep; i++)
                dist_rows[row][i] = hist[i];
            dist_rows[row][dep] = t_new;
        end else if (t_new < dist_rows[row][dep]) begin
            dist_rows[row][dep] = t_new;
        end else begin
            return 1'b0;
        end
        // Invalidate every slot past the new hit
        for (i = dep + 1; i < HISTORY_SIZE; i++)
            dist_rows[row][i] = DIST_INF;
        return 1'b1;
    endfunction

    // Watch both channels: predict on accept, compare on strobe
    always @(posedge i_clk) begin : watch
        t_verdict v;
        if (!i_rst_n) begin
            for (int r = 0; r < NUM_SAMPLES; r++)
                for (int s = 0; s < HISTORY_SIZE; s++)
                    dist_rows[r][s] = DIST_INF;
            verdict_q.delete();
            n_fail = 0;
        end else begin
            if (i_valid === 1'b1) begin
                if (verdict_q.size() == 0) begin
                    n_fail++;
                    $display("%0t: unexpected result: expected none, got accepted=%0b",
                             $time, i_accepted);
                end else begin
                    v = verdict_q.pop_front();
                    if (i_accepted !== v.accepted) begin
                        n_fail++;
                        $display("%0t: %s on sample %0d: accepted expected %0b, got %0b",
                                 $time, v.op.name(), v.sample, v.accepted, i_accepted);
                    end
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                v.sample   = i_sample;
                v.op       = t_op'(i_operation);
                v.accepted = predict_accepted(t_op'(i_operation), i_sample, i_depth,
                                              i_history, i_new_distance);
                verdict_q.push_back(v);
            end
        end
        o_pending    <= verdict_q.size();
        o_fail_count <= n_fail;
    end

endmodule

[verif/tb_hit_history_visibility_buffer.sv]
`timescale 1ns / 1ps

module tb_hit_history_visibility_buffer;

    import hhvb_pkg::*;

    localparam int NUM_SAMPLES = NUM_SAMPLES_DEF;
    localparam int POOL        = 16;
    localparam int PHASE_ITEMS = 284;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_start;
    logic                          o_busy;
    logic                          i_operation;
    logic [SAMPLE_W-1:0]           i_sample;
    logic [DEPTH_W-1:0]            i_depth;
    logic [DIST_W-1:0]             i_new_distance;
    logic [HIST_FIELDS-1:0][DIST_W-1:0] i_history;
    logic                          o_valid;
    logic                          o_accepted;

    int fail_count;
    int pending;

    // Last update path per pooled sample: history below depth, t at depth, infinity above
    logic [HISTORY_SIZE_DEF-1:0][DIST_W-1:0] ray_path [POOL];
    logic [SAMPLE_W-1:0]                     pool_sample [POOL];

    hit_history_visibility_buffer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_operation    (i_operation),
        .i_sample       (i_sample),
        .i_depth        (i_depth),
        .i_new_distance (i_new_distance),
        .i_history_0    (i_history[0]),
        .i_history_1    (i_history[1]),
        .i_history_2    (i_history[2]),
        .i_history_3    (i_history[3]),
        .i_history_4    (i_history[4]),
        .i_history_5    (i_history[5]),
        .i_history_6    (i_history[6]),
        .o_valid        (o_valid),
        .o_accepted     (o_accepted)
    );

    hhvb_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_busy         (o_busy),
        .i_operation    (i_operation),
        .i_sample       (i_sample),
        .i_depth        (i_depth),
        .i_new_distance (i_new_distance),
        .i_history      (i_history),
        .i_valid        (o_valid),
        .i_accepted     (o_accepted),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Present one item and hold it until the block takes it
    task automatic send_item(t_op op, logic [SAMPLE_W-1:0] sample,
                             logic [DEPTH_W-1:0] depth, logic [DIST_W-1:0] t_new,
                             logic [HIST_FIELDS-1:0][DIST_W-1:0] hist);
        i_start        <= 1'b1;
        i_operation    <= op;
        i_sample       <= sample;
        i_depth        <= depth;
        i_new_distance <= t_new;
        i_history      <= hist;
        do
            @(posedge i_clk);
        while (o_busy !== 1'b0);
    endtask

    // Hold off new items until every outstanding result has come back
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    // Pick a distance: mostly a narrow cluster so ties and near misses occur
    function automatic logic [DIST_W-1:0] pick_dist();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DIST_INF;
            2:       return '1;
            3:       return $urandom;
            default: return 32'h4000_0000 + $urandom_range(0, 15);
        endcase
    endfunction

    // Build one random item: mostly rays that follow a pooled row's path
    task automatic send_random_item();
        logic [HIST_FIELDS-1:0][DIST_W-1:0] h;
        logic [DIST_W-1:0]                  t_new;
        t_op                                op;
        int unsigned                        p;
        int unsigned                        dep;
        int unsigned                        j;
        if ($urandom_range(0, 99) < 20) begin
            for (int k = 0; k < HIST_FIELDS; k++)
                h[k] = $urandom;
            send_item(t_op'($urandom_range(0, 1)),
                      SAMPLE_W'($urandom_range(0, NUM_SAMPLES - 1)),
                      DEPTH_W'($urandom_range(0, 7)), $urandom, h);
        end else begin
            p   = $urandom_range(0, POOL - 1);
            dep = $urandom_range(0, 7);
            op  = ($urandom_range(0, 99) < 80) ? OP_UPDATE : OP_CHECK;
            for (int k = 0; k < HIST_FIELDS; k++)
                h[k] = (k < dep) ? ray_path[p][k] : $urandom;
            // Perturb one prefix slot: just above or below the row, or a picked distance
            if (dep > 0 && $urandom_range(0, 99) < 30) begin
                j = $urandom_range(0, dep - 1);
                case ($urandom_range(0, 2))
                    0:       h[j] = ray_path[p][j] + 1;
                    1:       h[j] = ray_path[p][j] - 1;
                    default: h[j] = pick_dist();
                endcase
            end
            if ($urandom_range(0, 1))
                t_new = ray_path[p][dep] - $urandom_range(0, 3);
            else
                t_new = pick_dist();
            if (op == OP_UPDATE) begin
                for (int k = 0; k < HISTORY_SIZE_DEF; k++)
                    ray_path[p][k] = (k < dep) ? h[k] : (k == dep) ? t_new : DIST_INF;
            end
            send_item(op, pool_sample[p], DEPTH_W'(dep), t_new, h);
        end
    endtask

    initial begin
        logic [HIST_FIELDS-1:0][DIST_W-1:0] h;
        int                                 idle_pct;
        i_rst_n        <= 1'b0;
        i_start        <= 1'b0;
        i_operation    <= OP_UPDATE;
        i_sample       <= '0;
        i_depth        <= '0;
        i_new_distance <= '0;
        i_history      <= '0;
        for (int p = 0; p < POOL; p++) begin
            pool_sample[p] = SAMPLE_W'($urandom_range(0, NUM_SAMPLES - 1));
            ray_path[p]    = {HISTORY_SIZE_DEF{DIST_INF}};
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty prefix, ties and infinity on a fresh row
        h = {HIST_FIELDS{DIST_INF}};
        send_item(OP_CHECK,  '0, '0, '0, h);
        send_item(OP_CHECK,  '0, 3'd7, '0, h);
        send_item(OP_UPDATE, '0, '0, DIST_INF, h);
        send_item(OP_UPDATE, '0, '0, '0, h);
        send_item(OP_UPDATE, '0, '0, '0, h);
        h[0] = '0;
        send_item(OP_CHECK,  '0, 3'd1, '0, h);

        // Deepest bounce on the last sample
        h = {HIST_FIELDS{DIST_INF}};
        send_item(OP_UPDATE, SAMPLE_W'(NUM_SAMPLES - 1), 3'd7, 32'h0000_0001, h);
        send_item(OP_CHECK,  SAMPLE_W'(NUM_SAMPLES - 1), 3'd7, '0, h);
        h[6] = '0;
        send_item(OP_UPDATE, SAMPLE_W'(NUM_SAMPLES - 1), 3'd7, '1, h);
        h[0] = '1;
        send_item(OP_UPDATE, SAMPLE_W'(NUM_SAMPLES - 1), 3'd7, '0, h);

        // Sign-bit pattern ranks above infinity; smaller history rewrites
        h = {HIST_FIELDS{DIST_INF}};
        h[0] = 32'h8000_0000;
        h[1] = '0;
        send_item(OP_UPDATE, 10'd5, 3'd2, '0, h);
        h[0] = '0;
        send_item(OP_UPDATE, 10'd5, 3'd2, '1, h);
        h[2] = '1;
        send_item(OP_CHECK,  10'd5, 3'd3, '0, h);
        send_item(OP_UPDATE, 10'd5, 3'd1, '0, h);
        send_item(OP_UPDATE, 10'd5, 3'd3, '0, h);
        h[1] = 32'h0000_0001;
        send_item(OP_CHECK,  10'd5, 3'd2, '0, h);

        // Alternating bit patterns and an all-ones larger history
        h = {HIST_FIELDS{32'h5555_5555}};
        h[1] = 32'hAAAA_AAAA;
        send_item(OP_UPDATE, 10'b10_1010_1010, 3'd4, 32'hAAAA_AAAA, h);
        h = {HIST_FIELDS{32'hFFFF_FFFF}};
        send_item(OP_UPDATE, 10'b01_0101_0101, 3'd7, '1, h);
        drain();

        // Random phases: sender idling light, heavy, then none
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 28 : (ph == 1) ? 74 : 0;
            repeat (PHASE_ITEMS) begin
                send_random_item();
                // Idle the sender cycle by cycle at the phase's rate
                while ($urandom_range(0, 99) < idle_pct) begin
                    i_start <= 1'b0;
                    @(posedge i_clk);
                end
            end
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Stop a hung run
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
